// ----- rtl/core/tes_pkg.sv -----
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants and types of the trailing escape stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SPACE_CNT_W = 6;
    localparam int unsigned MAX_SPACES  = 60;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'd32;
    localparam logic [BYTE_W-1:0] ESC_RESET    = 8'd92;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPACES,
        ST_HELD,
        ST_NEWLINE
    } tes_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // Latch the incoming byte as the current item.
        logic absorb;      // Non-emitting item: update count and held byte.
        logic emit_space;  // Put one pending space into the output register.
        logic emit_held;   // Put the held byte into the output register.
        logic emit_nl;     // Put a newline into the output register, clear line.
        logic take;        // The current byte becomes the held byte.
        logic out_last;    // Last flag for emit_held.
    } tes_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_nl;
        logic cur_is_nl;
        logic held_valid;
        logic held_is_space;
        logic held_is_esc;
        logic spaces_zero;
        logic spaces_one;
        logic out_free;
    } tes_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tes_datapath.sv -----
// ----------------------------------------------------------------------------
// tes_datapath
// Held byte, space counter, escape register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [tes_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire logic [tes_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic [tes_pkg::BYTE_W-1:0]     m_tdata,
    output logic                           m_tlast,
    input  wire tes_pkg::tes_cmd_t         cmd,
    output tes_pkg::tes_stat_t             stat
);
    import tes_pkg::*;

    logic [BYTE_W-1:0]      esc_reg;
    logic [BYTE_W-1:0]      cur_reg;
    logic [BYTE_W-1:0]      held_reg;
    logic                   held_valid_reg;
    logic [SPACE_CNT_W-1:0] pending_reg;
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg        <= ESC_RESET;
            held_valid_reg <= 1'b0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                esc_reg <= cfg_wr_data;
            end

            if (cmd.absorb) begin
                if (held_valid_reg && held_reg == SPACE_BYTE
                        && pending_reg < SPACE_CNT_W'(MAX_SPACES)) begin
                    pending_reg <= pending_reg + 1'b1;
                end
                held_valid_reg <= 1'b1;
            end else if (cmd.emit_space) begin
                pending_reg <= pending_reg - 1'b1;
            end else if (cmd.take) begin
                held_valid_reg <= 1'b1;
            end else if (cmd.emit_nl) begin
                held_valid_reg <= 1'b0;
                pending_reg    <= '0;
            end

            if (cmd.emit_space || cmd.emit_held || cmd.emit_nl) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= s_tdata;
        end
        if (cmd.absorb) begin
            held_reg <= s_tdata;
        end else if (cmd.take) begin
            held_reg <= cur_reg;
        end

        if (cmd.emit_space) begin
            out_data_reg <= SPACE_BYTE;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_held) begin
            out_data_reg <= held_reg;
            out_last_reg <= cmd.out_last;
        end else if (cmd.emit_nl) begin
            out_data_reg <= NEWLINE_BYTE;
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        stat.in_is_nl      = (s_tdata == NEWLINE_BYTE);
        stat.cur_is_nl     = (cur_reg == NEWLINE_BYTE);
        stat.held_valid    = held_valid_reg;
        stat.held_is_space = (held_reg == SPACE_BYTE);
        stat.held_is_esc   = (held_reg == esc_reg);
        stat.spaces_zero   = (pending_reg == '0);
        stat.spaces_one    = (pending_reg == SPACE_CNT_W'(1));
        stat.out_free      = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tes_ctrl.sv -----
// ----------------------------------------------------------------------------
// tes_ctrl
// Controller: accepts one byte, then sequences its spaces, held byte, newline.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire tes_pkg::tes_stat_t stat,
    output tes_pkg::tes_cmd_t       cmd
);
    import tes_pkg::*;

    tes_state_t state_reg;
    tes_state_t state_next;
    logic       emitting;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted byte sends out the held byte and its spaces when a byte is
    // held and either the byte is a newline and the held byte is not the escape,
    // or the byte is ordinary text and the held byte is not a space.
    assign emitting = stat.held_valid &&
                      (stat.in_is_nl ? !stat.held_is_esc : !stat.held_is_space);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (emitting) begin
                        state_next = stat.spaces_zero ? ST_HELD : ST_SPACES;
                    end else if (stat.in_is_nl) begin
                        state_next = ST_NEWLINE;
                    end else begin
                        cmd.absorb = 1'b1;
                    end
                end
            end
            ST_SPACES: begin
                if (stat.out_free) begin
                    cmd.emit_space = 1'b1;
                    if (stat.spaces_one) begin
                        state_next = ST_HELD;
                    end
                end
            end
            ST_HELD: begin
                if (stat.out_free) begin
                    cmd.emit_held = 1'b1;
                    cmd.out_last  = !stat.cur_is_nl;
                    if (stat.cur_is_nl) begin
                        state_next = ST_NEWLINE;
                    end else begin
                        cmd.take   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NEWLINE: begin
                if (stat.out_free) begin
                    cmd.emit_nl = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/trailing_escape_stripper_top.sv -----
// ----------------------------------------------------------------------------
// trailing_escape_stripper_top
// Byte-stream filter that removes a line-final escape and the spaces before it.
// ----------------------------------------------------------------------------
// This block applies the edit "s/ *esc$//" to a stream of text bytes. It keeps
// the most recent non-newline byte back, together with a count of the spaces
// in front of it that have not been sent yet. When a newline arrives and the
// held byte equals the escape character, the held byte and its spaces are
// dropped; otherwise they are sent ahead of the newline. A run of more than
// 60 spaces is cut to 60 before another byte, or to 61 when a newline ends
// it. A request that produces no output leaves the controller free for the
// next one; one that produces output keeps it busy while its output bytes
// (pending spaces, held byte, newline) are sent one per cycle through the
// output register, which stalls only while the sink deasserts m_tready.
// m_tlast marks the final output byte caused by an input request. The escape
// character must be written through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block does not enforce it. It resets to backslash. There
// is no end-of-stream flush: a held byte stays held until more input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module trailing_escape_stripper_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration: escape character.
    input  wire logic                      cfg_wr_en,
    input  wire logic [tes_pkg::BYTE_W-1:0] cfg_wr_data,
    // Input stream.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [tes_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    // Output stream.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [tes_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast    // last
);
    import tes_pkg::*;

    tes_cmd_t  cmd;
    tes_stat_t stat;

    // The controller sequences one input request at a time.
    tes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the line state and the output register.
    tes_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A newline always produces output, so the controller must go busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata == NEWLINE_BYTE) |=> !s_tready)
        else $error("newline request did not start an output sequence");

    // A newline on the output is always the final byte of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata == NEWLINE_BYTE) |-> m_tlast)
        else $error("output newline without last flag");

    // While the controller accepts input it issues no output command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.emit_space || cmd.emit_held || cmd.emit_nl))
        else $error("output command while accepting input");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trailing escape stripper.
// ----------------------------------------------------------------------------
// A generator fills a queue of text bytes: first a short directed line set,
// then random lines built from words, space runs and escape characters, mixed
// with raw noise bytes. A clocked driver feeds the input stream from that
// queue and a clocked monitor predicts the stripped text of every accepted
// request. It compares each output beat, data and last flag, with the oldest
// prediction. The escape register is rewritten between phases once the
// block has gone quiet, and the idling of both sides changes from phase to
// phase.
// ----------------------------------------------------------------------------

module tb_top;

    import tes_pkg::*;

    // One predicted output beat: the text byte and its last-of-request flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } text_beat_t;

    // Busy time of one request while the sink never stalls: a full space run, the
    // newline and the accepting step of the controller, with some margin.
    localparam int QUIET_CYCLES = 70;
    localparam int PHASE_ITEMS  = 50;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;

    // Bytes still to be offered, and the stripped text still to arrive.
    logic [BYTE_W-1:0] text_q[$];
    text_beat_t        stripped_q[$];

    // Our own copy of the block's line state and escape register.
    logic [BYTE_W-1:0]      line_held      = '0;
    logic                   line_held_vld  = 1'b0;
    logic [SPACE_CNT_W-1:0] line_spaces    = '0;
    logic [BYTE_W-1:0]      escape_reg     = ESC_RESET;

    logic              req_taken     = 1'b0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                errors        = 0;
    int                gen_count     = 0;
    text_beat_t        got_beat;

    trailing_escape_stripper_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out the output beats of one accepted byte and update the line state.
    // The last flag always falls on the final beat pushed for the request.
    function automatic void strip_byte(input logic [BYTE_W-1:0] b);
        int unsigned k;
        if (b == NEWLINE_BYTE) begin
            // The held byte and its spaces go out unless the held byte is the
            // escape; an empty line just passes the newline.
            if (line_held_vld && line_held != escape_reg) begin
                for (k = 0; k < line_spaces; k++)
                    stripped_q.push_back('{data: SPACE_BYTE, last: 1'b0});
                stripped_q.push_back('{data: line_held, last: 1'b0});
            end
            stripped_q.push_back('{data: NEWLINE_BYTE, last: 1'b1});
            line_held     = '0;
            line_held_vld = 1'b0;
            line_spaces   = '0;
        end else begin
            if (line_held_vld) begin
                if (line_held == SPACE_BYTE) begin
                    // A held space only grows the run, which saturates.
                    if (line_spaces < MAX_SPACES)
                        line_spaces = line_spaces + 1'b1;
                end else begin
                    for (k = 0; k < line_spaces; k++)
                        stripped_q.push_back('{data: SPACE_BYTE, last: 1'b0});
                    stripped_q.push_back('{data: line_held, last: 1'b1});
                    line_spaces = '0;
                end
            end
            line_held     = b;
            line_held_vld = 1'b1;
        end
    endfunction

    // Driver: the input stream and the sink's ready change on the falling edge.
    // A new request is taken from the queue only once the current one has been
    // accepted, so a held valid is never dropped and raised in the same step.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: requests are predicted and output beats are checked on the
    // rising edge. The prediction comes first so that the order of the two
    // never matters.
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken     <= 1'b0;
            line_held     = '0;
            line_held_vld = 1'b0;
            line_spaces   = '0;
            escape_reg    = ESC_RESET;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (cfg_wr_en)
                escape_reg = cfg_wr_data;
            if (s_tvalid && s_tready)
                strip_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (stripped_q.size() == 0) begin
                    $error("output byte %0d (last %0b) with nothing expected",
                           m_tdata, m_tlast);
                    errors++;
                end else begin
                    got_beat = stripped_q.pop_front();
                    if (m_tdata !== got_beat.data) begin
                        $error("out_byte: expected %0d, got %0d", got_beat.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== got_beat.last) begin
                        $error("last: expected %0b, got %0b", got_beat.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        text_q.push_back(b);
        gen_count++;
    endtask

    // One well-formed line: words, short space runs (now and then one long
    // enough to saturate the count) and stray escapes, then one of the line
    // endings that matter: escape, spaces and escape, spaces, or nothing.
    task automatic add_text_line(input logic [BYTE_W-1:0] esc);
        int                n_tok;
        int                run;
        logic [BYTE_W-1:0] b;
        n_tok = $urandom_range(0, 5);
        repeat (n_tok) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == NEWLINE_BYTE)
                            b = 8'h2E;
                        push_byte(b);
                    end
                end
                3: begin
                    run = ($urandom_range(0, 24) == 0) ? $urandom_range(58, 66)
                                                       : $urandom_range(1, 4);
                    repeat (run) push_byte(SPACE_BYTE);
                end
                default: begin
                    push_byte(esc);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                push_byte(esc);
            end
            1: begin
                repeat ($urandom_range(1, 3)) push_byte(SPACE_BYTE);
                push_byte(esc);
            end
            2: begin
                repeat ($urandom_range(1, 3)) push_byte(SPACE_BYTE);
            end
            default: begin
            end
        endcase
        push_byte(NEWLINE_BYTE);
    endtask

    // The escape register is only written while the block is quiet.
    task automatic write_escape(input logic [BYTE_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // The sender holds back here until every predicted beat has been seen,
    // and then the block gets time to finish any request without output.
    task automatic wait_quiet();
        while (text_q.size() != 0 || s_tvalid || stripped_q.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [BYTE_W-1:0] phase_escape [1:5];
        logic [BYTE_W-1:0] esc;
        int                ph;
        int                start_count;

        // Extremes, a space as escape (a held space before a newline is then
        // dropped with its run), a newline as escape, and one random value.
        phase_escape[1] = SPACE_BYTE;
        phase_escape[2] = 8'h00;
        phase_escape[3] = 8'hFF;
        phase_escape[4] = NEWLINE_BYTE;
        phase_escape[5] = 8'($urandom_range(0, 255));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed lines with the backslash as escape; the sender rarely idles
        // and the sink often does.
        send_idle_pct = 9;
        recv_idle_pct = 68;
        esc = ESC_RESET;
        write_escape(esc);
        // Newlines with nothing held give only the newline.
        push_byte(NEWLINE_BYTE);
        push_byte(NEWLINE_BYTE);
        // The field extremes pass through as held bytes.
        push_byte(8'h61);
        push_byte(8'h00);
        push_byte(8'hFF);
        // Spaces and then an escape ending the line: all of it is removed.
        push_byte(SPACE_BYTE);
        push_byte(SPACE_BYTE);
        push_byte(esc);
        push_byte(NEWLINE_BYTE);
        // An escape inside a line is ordinary text.
        push_byte(esc);
        push_byte(8'h78);
        push_byte(SPACE_BYTE);
        push_byte(NEWLINE_BYTE);
        // Spaces before a plain byte come out ahead of it at the newline.
        push_byte(8'h62);
        push_byte(SPACE_BYTE);
        push_byte(SPACE_BYTE);
        push_byte(8'h63);
        push_byte(NEWLINE_BYTE);
        wait_quiet();

        // Random phases: the idling of the two sides swaps after the first phase
        // and stops altogether for the last one.
        for (ph = 1; ph <= 5; ph++) begin
            if (ph >= 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (ph >= 2) begin
                send_idle_pct = 68;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 9;
                recv_idle_pct = 68;
            end
            esc = phase_escape[ph];
            write_escape(esc);
            start_count = gen_count;
            // A run far past the saturation point, once stripped and once kept.
            if (ph == 2 || ph == 5) begin
                repeat (64) push_byte(SPACE_BYTE);
                push_byte((ph == 2) ? esc : 8'h71);
                push_byte(NEWLINE_BYTE);
            end
            while (gen_count - start_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) begin
                    add_text_line(esc);
                end else begin
                    repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                end
            end
            wait_quiet();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Safety net against a stalled handshake.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tes_pkg.sv
rtl/core/tes_datapath.sv
rtl/core/tes_ctrl.sv
rtl/core/trailing_escape_stripper_top.sv
tb/sv/tb_top.sv
